// File: src/sed_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by sobel_edge_threshold; no dependencies.
package sed_pkg;

  localparam int MAX_LINE_WIDTH = 1024;

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int THR_W     = 11;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int GRAD_W    = 11;
  localparam int SUM_W     = 10;
  localparam int SQ_W      = 20;
  localparam int MAG_W     = 21;
  localparam int LIM_W     = 2 * (THR_W + 1);

  localparam logic [FW_W-1:0]  FW_RST  = FW_W'(640);
  localparam logic [FH_W-1:0]  FH_RST  = FH_W'(480);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(100);
  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'((100 + 1) * (100 + 1));

  localparam int MIN_DIM = 3;
  localparam int BORDER  = 2;

  localparam logic [PIX_W-1:0] EDGE_ON  = PIX_W'(255);
  localparam logic [PIX_W-1:0] EDGE_OFF = PIX_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } meta_t;

endpackage

// File: src/sed_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sed_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sobel_edge_threshold.sv
// Streaming 3x3 Sobel edge detector with magnitude threshold (top level).
// Depends on sed_pkg and sed_ram.
//
// Takes one 8-bit gray word per clock in raster order and returns one word per
// interior pixel, 255 where the squared Sobel gradient magnitude is at least
// (edge_threshold + 1)^2 and 0 elsewhere, tagged with its row, column and an
// end-of-frame flag, one pixel per clock unless the output stalls. A result
// passes stage 1, gradient, square and output registers. The two previous rows
// sit in one line memory, read when a pixel is taken and written back as its
// word leaves stage 1; consecutive pixels always touch different columns, so
// no interlock is needed. A fill pointer stands in for clearing the line memory
// at reset, so the block is ready right out of reset. The user must write
// configuration while the stream is idle (unenforced); it acts on the next pixel.
module sobel_edge_threshold #(
  parameter int MaxLineWidth = sed_pkg::MAX_LINE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [sed_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sed_pkg::PIX_W-1:0]      gray_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sed_pkg::PIX_W-1:0]      edge_value_o,
  output logic [sed_pkg::ROW_W-1:0]      out_row_o,
  output logic [sed_pkg::COL_W-1:0]      out_col_o,
  output logic                           frame_done_o
);

  localparam int AddrW = $clog2(MaxLineWidth);
  localparam int EwW   = $clog2(MaxLineWidth + 1);
  localparam int CmpW  = (EwW > sed_pkg::FW_W) ? EwW : sed_pkg::FW_W;
  localparam int RcW   = sed_pkg::FH_W + 1;
  localparam int PixW  = sed_pkg::PIX_W;

  // configuration
  logic [sed_pkg::FW_W-1:0]  fw_q;
  logic [sed_pkg::FH_W-1:0]  fh_q;
  logic [sed_pkg::THR_W-1:0] thr_q;
  logic [sed_pkg::LIM_W-1:0] lim_q, lim_d;
  logic [sed_pkg::THR_W:0]   thr_p1;

  // position and fill state
  logic [AddrW-1:0]             col_q, col_d;
  logic [sed_pkg::ROW_W-1:0]    row_q, row_d;
  logic [EwW-1:0]               fill_q, fill_d;

  // stage 1: line memory data back
  logic                         v1_q;
  logic [PixW-1:0]              px1_q;
  logic [AddrW-1:0]             col1_q;
  logic                         emit1_q;
  logic                         hit1_q;
  sed_pkg::meta_t               meta1_q;

  // stage 2: gradients
  logic                         v2_q;
  logic signed [sed_pkg::GRAD_W-1:0] gx2_q, gy2_q;
  sed_pkg::meta_t               meta2_q;

  // stage 3: squares
  logic                         v3_q;
  logic [sed_pkg::SQ_W-1:0]     sqx3_q, sqy3_q;
  sed_pkg::meta_t               meta3_q;

  // output register
  logic                         vo_q;
  logic [PixW-1:0]              edge_q;
  sed_pkg::meta_t               metao_q;

  // window: two previous columns, index 0 top row .. 2 bottom row
  logic [PixW-1:0]              wa_q [3];
  logic [PixW-1:0]              wb_q [3];
  logic [PixW-1:0]              wn   [3];

  logic ready1, ready2, ready3, ready_o;
  logic accept;

  logic [CmpW-1:0] fw_ext, max_ext, ew, col_ext, fill_ext, colm1;
  logic [RcW-1:0]  fh_ext, eh, row_ext;
  logic            last_col, last_row, emit0, hit0;

  logic                      ram_we;
  logic [2*PixW-1:0]         ram_rdata;
  logic [PixW-1:0]           top1, mid1;
  logic [sed_pkg::SUM_W-1:0] spx, snx, spy, sny;
  logic signed [sed_pkg::GRAD_W-1:0] gx1, gy1;
  logic signed [2*sed_pkg::GRAD_W-1:0] gx_sq, gy_sq;
  logic [sed_pkg::MAG_W-1:0] mag;
  logic                      is_edge;
  sed_pkg::meta_t            meta0;

  // handshake chain
  assign ready_o    = !vo_q || !out_stall_i;
  assign ready3     = !v3_q || ready_o;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;

  // effective frame size and position flags
  assign fw_ext   = CmpW'(fw_q);
  assign max_ext  = CmpW'(MaxLineWidth);
  assign col_ext  = CmpW'(col_q);
  assign fill_ext = CmpW'(fill_q);
  assign fh_ext   = RcW'(fh_q);
  assign row_ext  = RcW'(row_q);

  always_comb begin
    if (fw_ext < CmpW'(sed_pkg::MIN_DIM)) begin
      ew = CmpW'(sed_pkg::MIN_DIM);
    end else if (fw_ext > max_ext) begin
      ew = max_ext;
    end else begin
      ew = fw_ext;
    end
    if (fh_ext < RcW'(sed_pkg::MIN_DIM)) begin
      eh = RcW'(sed_pkg::MIN_DIM);
    end else begin
      eh = fh_ext;
    end
  end

  assign last_col = (col_ext + CmpW'(1)) >= ew;
  assign last_row = (row_ext + RcW'(1)) >= eh;
  assign emit0    = (row_q >= sed_pkg::ROW_W'(sed_pkg::BORDER)) &&
                    (col_ext >= CmpW'(sed_pkg::BORDER));
  assign hit0     = col_ext < fill_ext;
  assign colm1    = col_ext - CmpW'(1);

  always_comb begin
    meta0.row  = row_q - sed_pkg::ROW_W'(1);
    meta0.col  = colm1[sed_pkg::COL_W-1:0];
    meta0.done = last_col && last_row;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    fill_d = fill_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + sed_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
      if (col_ext == fill_ext) begin
        fill_d = fill_q + EwW'(1);
      end
    end
  end

  assign thr_p1 = {1'b0, thr_q} + (sed_pkg::THR_W + 1)'(1);
  assign lim_d  = sed_pkg::LIM_W'(thr_p1) * sed_pkg::LIM_W'(thr_p1);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= sed_pkg::FW_RST;
      fh_q   <= sed_pkg::FH_RST;
      thr_q  <= sed_pkg::THR_RST;
      lim_q  <= sed_pkg::LIM_RST;
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          sed_pkg::CFG_FRAME_WIDTH:    fw_q  <= cfg_data_i[sed_pkg::FW_W-1:0];
          sed_pkg::CFG_FRAME_HEIGHT:   fh_q  <= cfg_data_i[sed_pkg::FH_W-1:0];
          sed_pkg::CFG_EDGE_THRESHOLD: thr_q <= cfg_data_i[sed_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      lim_q  <= lim_d;
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
      if (ready1) begin
        v1_q <= accept;
      end
      if (ready2) begin
        v2_q <= v1_q && emit1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready_o) begin
        vo_q <= v3_q;
      end
    end
  end

  // line memory: {upper, middle} per column
  assign ram_we = v1_q && ready2;

  sed_ram #(
    .Width (2 * PixW),
    .Depth (MaxLineWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col1_q),
    .wdata_i ({mid1, px1_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // never-written columns read as zero
  assign top1 = hit1_q ? ram_rdata[2*PixW-1:PixW] : '0;
  assign mid1 = hit1_q ? ram_rdata[PixW-1:0]      : '0;

  assign wn[0] = top1;
  assign wn[1] = mid1;
  assign wn[2] = px1_q;

  assign spx = sed_pkg::SUM_W'(wn[0]) + {1'b0, wn[1], 1'b0} + sed_pkg::SUM_W'(wn[2]);
  assign snx = sed_pkg::SUM_W'(wa_q[0]) + {1'b0, wa_q[1], 1'b0} + sed_pkg::SUM_W'(wa_q[2]);
  assign spy = sed_pkg::SUM_W'(wa_q[2]) + {1'b0, wb_q[2], 1'b0} + sed_pkg::SUM_W'(wn[2]);
  assign sny = sed_pkg::SUM_W'(wa_q[0]) + {1'b0, wb_q[0], 1'b0} + sed_pkg::SUM_W'(wn[0]);
  assign gx1 = $signed({1'b0, spx}) - $signed({1'b0, snx});
  assign gy1 = $signed({1'b0, spy}) - $signed({1'b0, sny});

  assign gx_sq = gx2_q * gx2_q;
  assign gy_sq = gy2_q * gy2_q;

  assign mag     = sed_pkg::MAG_W'(sqx3_q) + sed_pkg::MAG_W'(sqy3_q);
  assign is_edge = sed_pkg::LIM_W'(mag) >= lim_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ready1) begin
      px1_q   <= gray_pixel_i;
      col1_q  <= col_q;
      emit1_q <= emit0;
      hit1_q  <= hit0;
      meta1_q <= meta0;
    end
    if (ram_we) begin
      for (int i = 0; i < 3; i++) begin
        wa_q[i] <= wb_q[i];
        wb_q[i] <= wn[i];
      end
    end
    if (ready2) begin
      gx2_q   <= gx1;
      gy2_q   <= gy1;
      meta2_q <= meta1_q;
    end
    if (ready3) begin
      sqx3_q  <= gx_sq[sed_pkg::SQ_W-1:0];
      sqy3_q  <= gy_sq[sed_pkg::SQ_W-1:0];
      meta3_q <= meta2_q;
    end
    if (ready_o) begin
      edge_q  <= is_edge ? sed_pkg::EDGE_ON : sed_pkg::EDGE_OFF;
      metao_q <= meta3_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign edge_value_o = edge_q;
  assign out_row_o    = metao_q.row;
  assign out_col_o    = metao_q.col;
  assign frame_done_o = metao_q.done;

  // read and write-back never hit the same column in one cycle
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ram_we |-> col_q != col1_q)
    else $error("line memory read and write collide");

  // columns are filled in order, so the read column is never past the fill pointer
  a_fill_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> col_ext <= fill_ext)
    else $error("column beyond fill pointer");

  // a held stage 1 word keeps its column until it moves on
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !ready2 |=> v1_q && $stable(col1_q))
    else $error("stage 1 word lost while held");

  // interior results never sit on row zero
  a_interior_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o != '0)
    else $error("result on border row");

endmodule
